// File: rtl/gnt_pkg.sv
package gnt_pkg;

  // Field widths of the request and result channels
  localparam int ACTION_W   = 2;
  localparam int OP_W       = 3;
  localparam int SRC_W      = 8;
  localparam int ROW_W      = 6;
  localparam int OUT_BITS_W = 16;
  localparam int OBIT_IDX_W = 4;
  localparam int CFG_W      = 3;
  localparam int SRC_VALS   = 2 ** SRC_W;

  // Defaults for the top-level parameters
  localparam int NUM_VARS_DEF    = 256;
  localparam int MAX_GATES_DEF   = 256;
  localparam int MAX_OUTPUTS_DEF = 16;
  localparam int MAX_INPUTS_DEF  = 6;

  // Fixed variable indexes
  localparam int CONST0_VAR      = 0;
  localparam int CONST1_VAR      = 1;
  localparam int FIRST_INPUT_VAR = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_GATE  = 2'd1,
    ACT_OUT   = 2'd2,
    ACT_RUN   = 2'd3
  } action_e;

  typedef enum logic [OP_W-1:0] {
    OP_XOR  = 3'd0,
    OP_AND  = 3'd1,
    OP_NAND = 3'd2,
    OP_NOR  = 3'd3,
    OP_OR   = 3'd4,
    OP_NOT  = 3'd5,
    OP_PASS = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_GATE,
    ST_OUTS,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [OP_W-1:0]     gate_op;
    logic [SRC_W-1:0]    source_a;
    logic [SRC_W-1:0]    source_b;
    logic [SRC_W-1:0]    target_var;
  } req_t;

  typedef struct packed {
    logic [ROW_W-1:0]      row_value;
    logic [OUT_BITS_W-1:0] output_bits;
    logic                  last_row;
  } res_t;

  function automatic logic apply_gate(op_e op, logic x, logic y);
    logic r;
    case (op)
      OP_XOR:  r = x ^ y;
      OP_AND:  r = x & y;
      OP_NAND: r = ~(x & y);
      OP_NOR:  r = ~(x | y);
      OP_OR:   r = x | y;
      OP_NOT:  r = ~x;
      OP_PASS: r = x;
      default: r = x;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/gnt_req_if.sv
interface gnt_req_if;
  logic           valid;
  logic           ready;
  gnt_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/gnt_res_if.sv
interface gnt_res_if;
  logic           valid;
  logic           ready;
  gnt_pkg::res_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/gate_netlist_truth_table.sv
// Truth-table evaluator for a loaded gate netlist. Requests on req_i either
// edit the program (clear, append a gate, append an output variable) or run
// it. Edits give no result. A run walks rows 0 .. 2^n-1 (n = input_count,
// clamped to 1..MAX_INPUTS) and returns one result per row on res_o: the row
// number, the packed output variables and a last flag on the final row. For
// each row the block loads the n input variables, runs the G loaded gates and
// reads the K listed outputs (at most sixteen): inputs and gates go one at a
// time through the single write port of the variable store, outputs through
// its read port a, and the read-compute-write pipeline then drains. The
// variable store is not cleared between rows or runs. After reset the block
// zeroes the variable store and takes no request meanwhile; configuration
// writes are taken at any time, but only change a run that starts later.
module gate_netlist_truth_table #(
  parameter int NUM_VARS    = gnt_pkg::NUM_VARS_DEF,
  parameter int MAX_GATES   = gnt_pkg::MAX_GATES_DEF,
  parameter int MAX_OUTPUTS = gnt_pkg::MAX_OUTPUTS_DEF,
  parameter int MAX_INPUTS  = gnt_pkg::MAX_INPUTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [gnt_pkg::CFG_W-1:0] cfg_wdata_i,
  gnt_req_if.sink                   req_i,
  gnt_res_if.source                 res_o
);

  import gnt_pkg::*;

  localparam int VW   = $clog2(NUM_VARS);
  localparam int PAW  = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
  localparam int GCW  = $clog2(MAX_GATES + 1);
  localparam int OAW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int OCW  = $clog2(MAX_OUTPUTS + 1);
  localparam int PW   = OP_W + 3 * VW;
  localparam int OLIM = (MAX_OUTPUTS < OUT_BITS_W) ? MAX_OUTPUTS : OUT_BITS_W;

  // ------------------------------------------------------------------
  // Control state
  // ------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [VW-1:0]    clr_q;
  logic [CFG_W-1:0] j_q;
  logic [PAW-1:0]   g_q;
  logic [OAW-1:0]   k_q;
  logic [GCW-1:0]   gtotal_q;
  logic [OCW-1:0]   ototal_q;
  logic [CFG_W-1:0] cfg_q;
  logic [CFG_W-1:0] n_q;
  logic [ROW_W-1:0] row_q;
  logic             res_valid_q;

  // Pipeline tags: gate path (program read, store read) and output path
  // (map read, store read).
  logic pv1_q, pv2_q, ov1_q, ov2_q;

  // Payload registers
  logic [OP_W-1:0]       op2_q;
  logic [VW-1:0]         a2_q, b2_q, t2_q;
  logic [OAW-1:0]        k1_q, k2_q;
  logic                  wr_prev_en_q;
  logic [VW-1:0]         wr_prev_addr_q;
  logic                  wr_prev_data_q;
  logic [OUT_BITS_W-1:0] bits_q;
  res_t                  res_data_q;

  // FSM outputs
  logic req_ready, clr_we, load_we, gate_issue, out_issue, emit;

  // ------------------------------------------------------------------
  // Index reduction table: source field modulo NUM_VARS
  // ------------------------------------------------------------------
  logic [VW-1:0] mod_lut [SRC_VALS];

  for (genvar v = 0; v < SRC_VALS; v++) begin : g_mod
    assign mod_lut[v] = VW'(v % NUM_VARS);
  end

  // ------------------------------------------------------------------
  // Derived run quantities
  // ------------------------------------------------------------------
  logic [CFG_W-1:0] n_eff;
  logic [OCW-1:0]   olim;
  logic [ROW_W-1:0] row_mask;
  logic [CFG_W-1:0] bit_sel;
  logic [ROW_W-1:0] row_shift;
  logic             last_row;
  logic             has_gates, has_outs;
  logic             load_last, gate_last, out_last;
  logic             pipes_idle;
  logic             req_acc;
  action_e          act;

  always_comb begin
    if (cfg_q == '0) begin
      n_eff = CFG_W'(1);
    end else if (cfg_q > CFG_W'(MAX_INPUTS)) begin
      n_eff = CFG_W'(MAX_INPUTS);
    end else begin
      n_eff = cfg_q;
    end
  end

  assign olim      = (ototal_q > OCW'(OLIM)) ? OCW'(OLIM) : ototal_q;
  assign row_mask  = ROW_W'((7'd1 << n_q) - 7'd1);
  assign last_row  = (row_q == row_mask);
  // Row bit for input variable j: most significant bit goes to the first
  assign bit_sel   = CFG_W'(n_q - CFG_W'(1) - j_q);
  assign row_shift = row_q >> bit_sel;
  assign has_gates = (gtotal_q != '0);
  assign has_outs  = (olim != '0);
  assign load_last = (j_q == CFG_W'(n_q - CFG_W'(1)));
  assign gate_last = (GCW'(g_q) == GCW'(gtotal_q - GCW'(1)));
  assign out_last  = (OCW'(k_q) == OCW'(olim - OCW'(1)));
  assign pipes_idle = !(pv1_q || pv2_q || ov1_q || ov2_q);
  assign act       = action_e'(req_i.data.action);
  assign req_acc   = req_i.valid && req_ready;

  // ------------------------------------------------------------------
  // Memories
  // ------------------------------------------------------------------
  logic              prog_we;
  logic [PAW-1:0]    prog_waddr;
  logic [PW-1:0]     prog_wdata, prog_rdata;
  logic              map_we;
  logic [OAW-1:0]    map_waddr;
  logic [VW-1:0]     map_rdata;
  logic              st_we;
  logic [VW-1:0]     st_waddr;
  logic              st_wdata;
  logic [VW-1:0]     st_raddr_a;
  logic              st_rdata_a, st_rdata_b;

  logic [OP_W-1:0]   prog_op;
  logic [VW-1:0]     prog_a, prog_b, prog_t;

  assign {prog_op, prog_a, prog_b, prog_t} = prog_rdata;

  assign prog_we    = req_acc && (act == ACT_GATE)
                      && (req_i.data.gate_op <= OP_PASS)
                      && (gtotal_q < GCW'(MAX_GATES));
  assign prog_waddr = gtotal_q[PAW-1:0];
  assign prog_wdata = {req_i.data.gate_op,
                       mod_lut[req_i.data.source_a],
                       mod_lut[req_i.data.source_b],
                       mod_lut[req_i.data.target_var]};

  assign map_we    = req_acc && (act == ACT_OUT) && (ototal_q < OCW'(MAX_OUTPUTS));
  assign map_waddr = ototal_q[OAW-1:0];

  gnt_ram #(.WIDTH(PW), .DEPTH(MAX_GATES)) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (prog_waddr),
    .wdata_i (prog_wdata),
    .raddr_i (g_q),
    .rdata_o (prog_rdata)
  );

  gnt_ram #(.WIDTH(VW), .DEPTH(MAX_OUTPUTS)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (mod_lut[req_i.data.target_var]),
    .raddr_i (k_q),
    .rdata_o (map_rdata)
  );

  // Port a serves the gate's first source or the listed output variable;
  // the two paths never issue in the same cycle.
  assign st_raddr_a = pv1_q ? prog_a : map_rdata;

  // Gate result, with constants and one-deep forwarding of the last write
  logic va, vb, gres;

  function automatic logic var_val(logic [VW-1:0] idx, logic ram_bit, logic fwd_en,
                                   logic [VW-1:0] fwd_addr, logic fwd_data);
    logic r;
    if (idx == VW'(CONST0_VAR)) begin
      r = 1'b0;
    end else if (idx == VW'(CONST1_VAR)) begin
      r = 1'b1;
    end else if (fwd_en && (fwd_addr == idx)) begin
      r = fwd_data;
    end else begin
      r = ram_bit;
    end
    return r;
  endfunction

  assign va   = var_val(a2_q, st_rdata_a, wr_prev_en_q, wr_prev_addr_q, wr_prev_data_q);
  assign vb   = var_val(b2_q, st_rdata_b, wr_prev_en_q, wr_prev_addr_q, wr_prev_data_q);
  assign gres = apply_gate(op_e'(op2_q), va, vb);

  // Single write port: clearing pass, input loading, gate write-back
  always_comb begin
    st_we    = 1'b0;
    st_waddr = t2_q;
    st_wdata = gres;
    if (clr_we) begin
      st_we    = 1'b1;
      st_waddr = clr_q;
      st_wdata = 1'b0;
    end else if (load_we) begin
      st_we    = 1'b1;
      st_waddr = VW'(FIRST_INPUT_VAR) + VW'(j_q);
      st_wdata = row_shift[0];
    end else if (pv2_q && (t2_q > VW'(CONST1_VAR))) begin
      st_we    = 1'b1;
    end
  end

  // Two copies of the store give both gate sources in the same cycle
  gnt_ram #(.WIDTH(1), .DEPTH(NUM_VARS)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr_a),
    .rdata_o (st_rdata_a)
  );

  gnt_ram #(.WIDTH(1), .DEPTH(NUM_VARS)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (prog_b),
    .rdata_o (st_rdata_b)
  );

  // ------------------------------------------------------------------
  // Sequencer: next state
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == VW'(NUM_VARS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_i.valid && (act == ACT_RUN)) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (load_last) begin
          if (has_gates)     state_d = ST_GATE;
          else if (has_outs) state_d = ST_OUTS;
          else               state_d = ST_DRAIN;
        end
      end
      ST_GATE: begin
        if (gate_last) state_d = has_outs ? ST_OUTS : ST_DRAIN;
      end
      ST_OUTS: begin
        if (out_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (emit) state_d = last_row ? ST_IDLE : ST_LOAD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer: outputs
  // ------------------------------------------------------------------
  always_comb begin
    req_ready  = 1'b0;
    clr_we     = 1'b0;
    load_we    = 1'b0;
    gate_issue = 1'b0;
    out_issue  = 1'b0;
    emit       = 1'b0;
    case (state_q)
      ST_CLEAR: clr_we     = 1'b1;
      ST_IDLE:  req_ready  = 1'b1;
      ST_LOAD:  load_we    = 1'b1;
      ST_GATE:  gate_issue = 1'b1;
      ST_OUTS:  out_issue  = 1'b1;
      ST_DRAIN: emit       = pipes_idle && (!res_valid_q || res_o.ready);
      default:  req_ready  = 1'b0;
    endcase
  end

  assign req_i.ready = req_ready;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_data_q;

  // ------------------------------------------------------------------
  // Control registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      j_q          <= '0;
      g_q          <= '0;
      k_q          <= '0;
      gtotal_q     <= '0;
      ototal_q     <= '0;
      cfg_q        <= CFG_RESET;
      n_q          <= CFG_W'(1);
      row_q        <= '0;
      res_valid_q  <= 1'b0;
      pv1_q        <= 1'b0;
      pv2_q        <= 1'b0;
      ov1_q        <= 1'b0;
      ov2_q        <= 1'b0;
      wr_prev_en_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      pv1_q        <= gate_issue;
      pv2_q        <= pv1_q;
      ov1_q        <= out_issue;
      ov2_q        <= ov1_q;
      wr_prev_en_q <= st_we;

      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (clr_we)   clr_q <= clr_q + VW'(1);

      // Advance the per-row counters; rewind when their phase ends
      if (load_we)    j_q <= load_last ? '0 : j_q + CFG_W'(1);
      if (gate_issue) g_q <= gate_last ? '0 : g_q + PAW'(1);
      if (out_issue)  k_q <= out_last  ? '0 : k_q + OAW'(1);

      if (req_acc) begin
        case (act)
          ACT_CLEAR: begin
            gtotal_q <= '0;
            ototal_q <= '0;
          end
          ACT_GATE: begin
            if (prog_we) gtotal_q <= gtotal_q + GCW'(1);
          end
          ACT_OUT: begin
            if (map_we) ototal_q <= ototal_q + OCW'(1);
          end
          ACT_RUN: begin
            n_q   <= n_eff;
            row_q <= '0;
          end
          default: n_q <= n_q;
        endcase
      end

      if (emit) begin
        res_valid_q <= 1'b1;
        row_q       <= row_q + ROW_W'(1);
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Payload registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    op2_q          <= prog_op;
    a2_q           <= st_raddr_a;
    b2_q           <= prog_b;
    t2_q           <= prog_t;
    k1_q           <= k_q;
    k2_q           <= k1_q;
    wr_prev_addr_q <= st_waddr;
    wr_prev_data_q <= st_wdata;

    // Drop the collected bits at each row boundary and on every accepted request
    if (emit || req_acc) begin
      bits_q <= '0;
    end else if (ov2_q) begin
      bits_q[OBIT_IDX_W'(k2_q)] <= va;
    end

    if (emit) begin
      res_data_q.row_value   <= row_q;
      res_data_q.output_bits <= bits_q;
      res_data_q.last_row    <= last_row;
    end
  end

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_port_a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pv1_q && ov1_q))
    else $error("store read port a claimed by gate and output paths");

  a_load_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> !pv2_q)
    else $error("gate write-back overlaps input loading");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> pipes_idle)
    else $error("request taken while the evaluation pipeline is busy");

  a_res_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == ST_DRAIN))
    else $error("result launched outside the drain phase");

  a_gate_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gtotal_q <= GCW'(MAX_GATES))
    else $error("gate count beyond program depth");

endmodule

// File: rtl/gnt_ram.sv
module gnt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
